// ----- hdl/dwt97_pkg.sv -----
package dwt97_pkg;

	localparam int MaxLen = 64;
	localparam int Depth  = 36;
	localparam int LenW   = 7;
	localparam int SmpW   = 24;
	localparam int CoefW  = 18;
	localparam int PosW   = 5;
	localparam int AddrW  = 6;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_LINE_LENGTH = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_START_ODD   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LIFT_A      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LIFT_B      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LIFT_C      = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LIFT_D      = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_HIGH_GAIN   = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_LOW_GAIN    = 3'd7;

	typedef logic signed [SmpW-1:0]  smp_t;
	typedef logic signed [CoefW-1:0] coef_t;

	// Item handed from the loader to the transform engine.
	typedef struct packed {
		smp_t             sample;
		logic [LenW-1:0]  index;
		logic             line_end;
	} fq_item_t;

	function automatic smp_t sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) return 24'sh7fffff;
		if (v < -48'sd8388608) return 24'sh800000;
		return v[SmpW-1:0];
	endfunction

endpackage

// ----- hdl/dwt97_front.sv -----
module dwt97_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	output logic                       stall,
	input  dwt97_pkg::smp_t            sample,
	input  logic [dwt97_pkg::LenW-1:0] eff_len,
	output logic                       q_push,
	output dwt97_pkg::fq_item_t        q_data,
	input  logic                       q_full
);
	import dwt97_pkg::*;

	logic [LenW-1:0] count_q;
	logic [LenW-1:0] k;
	logic [LenW-1:0] k_next;

	assign stall = q_full;
	assign k = (count_q >= LenW'(MaxLen)) ? LenW'(MaxLen - 1) : count_q;
	assign k_next = k + LenW'(1);
	assign q_push = valid && !q_full;
	assign q_data.sample = sample;
	assign q_data.index = k;
	assign q_data.line_end = (k_next >= eff_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= q_data.line_end ? '0 : k_next;
		end
	end
endmodule

// ----- hdl/dwt97_fifo.sv -----
module dwt97_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dwt97_pkg::fq_item_t wdata,
	output logic                full,
	input  logic                pop,
	output dwt97_pkg::fq_item_t rdata,
	output logic                nempty
);
	import dwt97_pkg::*;

	fq_item_t  mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'd4);
	assign nempty = (cnt_q != 3'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

// ----- hdl/dwt97_back.sv -----
module dwt97_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_nempty,
	input  dwt97_pkg::fq_item_t          q_data,
	output logic                         q_pop,
	input  logic [dwt97_pkg::LenW-1:0]   eff_len,
	input  logic                         start_odd,
	input  dwt97_pkg::coef_t             lift_a,
	input  dwt97_pkg::coef_t             lift_b,
	input  dwt97_pkg::coef_t             lift_c,
	input  dwt97_pkg::coef_t             lift_d,
	input  dwt97_pkg::coef_t             high_gain,
	input  dwt97_pkg::coef_t             low_gain,
	output logic                         out_valid,
	input  logic                         out_stall,
	output dwt97_pkg::smp_t              coefficient,
	output logic                         band,
	output logic [dwt97_pkg::PosW-1:0]   position,
	output logic                         last
);
	import dwt97_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_BUILD, ST_LIFT_RD, ST_LIFT_MUL, ST_LIFT_WR,
		ST_OUT_RD, ST_OUT_MUL, ST_OUT_WR, ST_OUT_WAIT
	} state_t;

	// Line buffer (by line index), p, g and w working arrays.
	smp_t line_mem [MaxLen];
	smp_t g_mem [Depth];
	smp_t p_mem [Depth];
	smp_t w_mem [Depth];

	state_t state_q;
	logic [1:0] pass_q;
	logic [AddrW-1:0] i_q;
	logic [AddrW-1:0] np_q;
	logic [AddrW-1:0] nlow_q;
	logic [LenW-1:0]  len_q;
	logic             s_q;
	logic             single_q;
	logic             oband_q;
	smp_t             opa_q, opb_q, base_q;
	logic signed [47:0] prod_q;
	smp_t             lm_rd_q;
	logic             build_ph_q;

	// Mirror a line index (2*i - 4 + s etc.) into 0..len-1.
	function automatic logic [LenW-1:0] mirror(input logic signed [8:0] j,
			input logic [LenW-1:0] len);
		logic signed [8:0] per;
		logic signed [8:0] r;
		per = 9'sd2 * ($signed({2'b0, len}) - 9'sd1);
		r = j;
		if (r < 0) r = -r;
		// a two-sample line can reach past two whole periods
		if (r >= per) r = r - per;
		if (r >= per) r = r - per;
		if (r > $signed({2'b0, len}) - 9'sd1) r = per - r;
		return r[LenW-1:0];
	endfunction

	logic signed [8:0] bj;
	logic [LenW-1:0]   baddr;
	logic [AddrW-1:0]  i_n;
	logic [AddrW-1:0]  lim;
	logic [AddrW-1:0]  nhigh;
	logic signed [SmpW:0] sum;
	coef_t             cur_c;
	logic signed [47:0] qm;
	smp_t              lres;

	assign i_n = i_q + AddrW'(1);
	assign nhigh = AddrW'(len_q) - nlow_q;
	assign bj = build_ph_q ? (9'sd2 * $signed({3'b0, i_q}) - 9'sd3 + $signed({8'b0, s_q}))
			: (9'sd2 * $signed({3'b0, i_q}) - 9'sd4 + $signed({8'b0, s_q}));
	assign baddr = mirror(bj, len_q);

	always_comb begin
		case (pass_q)
			2'd0: lim = np_q;
			2'd1: lim = np_q - AddrW'(1);
			2'd2: lim = np_q - AddrW'(2);
			default: lim = np_q - AddrW'(3);
		endcase
		case (pass_q)
			2'd0: cur_c = lift_a;
			2'd1: cur_c = lift_b;
			2'd2: cur_c = lift_c;
			default: cur_c = lift_d;
		endcase
	end

	// keep the carry bit of the pair sum
	assign sum = $signed({opa_q[SmpW-1], opa_q}) + $signed({opb_q[SmpW-1], opb_q});
	assign qm = (prod_q + 48'sd32768) >>> 16;
	assign lres = sat24(48'(base_q) + qm);

	assign q_pop = (state_q == ST_LOAD) && q_nempty;

	always_ff @(posedge clk) begin
		if (q_pop) line_mem[q_data.index[AddrW-1:0]] <= q_data.sample;
		lm_rd_q <= line_mem[baddr[AddrW-1:0]];
	end

	// Operand registers read entries i and i+1 of each working array.
	smp_t ga_q, gb_q, pa_q, pb_q, wa_q, wb_q;
	always_ff @(posedge clk) begin
		ga_q <= g_mem[i_q];
		gb_q <= g_mem[i_n];
		pa_q <= p_mem[i_q];
		pb_q <= p_mem[i_n];
		wa_q <= w_mem[i_q];
		wb_q <= w_mem[i_n];
	end

	// high band takes p[i + 1 - s]
	smp_t obase;
	assign obase = oband_q ? (s_q ? pa_q : pb_q) : wa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pass_q <= '0;
			i_q <= '0;
			np_q <= '0;
			nlow_q <= '0;
			len_q <= '0;
			s_q <= 1'b0;
			single_q <= 1'b0;
			oband_q <= 1'b0;
			build_ph_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (q_pop && q_data.line_end) begin
						len_q <= eff_len;
						s_q <= start_odd;
						single_q <= (eff_len == LenW'(1));
						nlow_q <= AddrW'((eff_len + LenW'(1) - LenW'(start_odd)) >> 1);
						np_q <= AddrW'((eff_len + LenW'(1) - LenW'(start_odd)) >> 1)
								+ AddrW'(3);
						i_q <= '0;
						build_ph_q <= 1'b0;
						pass_q <= '0;
						state_q <= (eff_len == LenW'(1)) ? ST_OUT_RD : ST_BUILD;
						oband_q <= 1'b0;
					end
				end
				ST_BUILD: begin
					// each step sets the address, then writes from the registered read
					if (!single_q) begin
						single_q <= 1'b1;
					end else begin
						single_q <= 1'b0;
						if (build_ph_q) p_mem[i_q] <= lm_rd_q;
						else g_mem[i_q] <= lm_rd_q;
						if (!build_ph_q) begin
							if (i_q == np_q) begin
								i_q <= '0;
								build_ph_q <= 1'b1;
							end else i_q <= i_n;
						end else if (i_q == np_q - AddrW'(1)) begin
							i_q <= '0;
							state_q <= ST_LIFT_RD;
						end else i_q <= i_n;
					end
				end
				ST_LIFT_RD: state_q <= ST_LIFT_MUL;
				ST_LIFT_MUL: begin
					case (pass_q)
						2'd0: begin opa_q <= ga_q; opb_q <= gb_q; base_q <= pa_q; end
						2'd1: begin opa_q <= pa_q; opb_q <= pb_q; base_q <= gb_q; end
						2'd2: begin opa_q <= wa_q; opb_q <= wb_q; base_q <= pb_q; end
						default: begin opa_q <= pa_q; opb_q <= pb_q; base_q <= wb_q; end
					endcase
					state_q <= ST_LIFT_WR;
					single_q <= 1'b0;
				end
				ST_LIFT_WR: begin
					if (!single_q) begin
						prod_q <= 48'(sum) * 48'(cur_c);
						single_q <= 1'b1;
					end else begin
						single_q <= 1'b0;
						if (pass_q == 2'd0 || pass_q == 2'd2) p_mem[i_q] <= lres;
						else w_mem[i_q] <= lres;
						if (i_n == lim) begin
							i_q <= '0;
							if (pass_q == 2'd3) state_q <= ST_OUT_RD;
							else begin
								pass_q <= pass_q + 2'd1;
								state_q <= ST_LIFT_RD;
							end
						end else begin
							i_q <= i_n;
							state_q <= ST_LIFT_RD;
						end
					end
				end
				ST_OUT_RD: begin
					if (single_q) begin
						coefficient <= line_mem[0];
						band <= 1'b0;
						position <= '0;
						last <= 1'b1;
						out_valid <= 1'b1;
						state_q <= ST_OUT_WAIT;
					end else begin
						state_q <= ST_OUT_MUL;
					end
				end
				ST_OUT_MUL: begin
					prod_q <= 48'(obase) * 48'(oband_q ? high_gain : low_gain);
					state_q <= ST_OUT_WR;
				end
				ST_OUT_WR: begin
					coefficient <= sat24(qm);
					band <= oband_q;
					position <= i_q[PosW-1:0];
					last <= oband_q ? (i_n == nhigh) : (nhigh == '0 && i_n == nlow_q);
					out_valid <= 1'b1;
					state_q <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last) begin
							single_q <= 1'b0;
							state_q <= ST_LOAD;
						end else if (!oband_q && i_n == nlow_q) begin
							oband_q <= 1'b1;
							i_q <= '0;
							state_q <= ST_OUT_RD;
						end else begin
							i_q <= i_n;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- hdl/dwt97_forward_lifting_1d_core.sv -----
// Forward 9/7 lifting wavelet over one line of up to 64 Q16.8 samples.
// Samples are taken one per cycle, unless stalled, into a four-entry queue and a line
// buffer; after the last sample of a line (line_length, 0 treated as 1) the engine
// mirrors the edges, runs four lifting passes one product at a time, then emits
// the low band times low_gain followed by the high band times high_gain; a
// one-sample line is emitted unscaled. Input stalls once the queue fills while
// the engine works. Write configuration only while the block is idle.
module dwt97_forward_lifting_1d_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dwt97_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [17:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dwt97_pkg::smp_t               sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dwt97_pkg::smp_t               coefficient,
	output logic                          band,
	output logic [dwt97_pkg::PosW-1:0]    position,
	output logic                          last
);
	import dwt97_pkg::*;

	logic [LenW-1:0] line_length_q;
	logic            start_odd_q;
	coef_t lift_a_q, lift_b_q, lift_c_q, lift_d_q, high_gain_q, low_gain_q;
	logic [LenW-1:0] eff_len;

	assign cfg_ready = 1'b1;
	assign eff_len = (line_length_q == '0) ? LenW'(1)
			: (line_length_q > LenW'(MaxLen)) ? LenW'(MaxLen) : line_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LenW'(MaxLen);
			start_odd_q <= 1'b0;
			lift_a_q <= -18'sd103950;
			lift_b_q <= -18'sd3472;
			lift_c_q <= 18'sd57862;
			lift_d_q <= 18'sd29065;
			high_gain_q <= 18'sd80620;
			low_gain_q <= 18'sd53274;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data[LenW-1:0];
				REG_START_ODD:   start_odd_q <= cfg_data[0];
				REG_LIFT_A:      lift_a_q <= cfg_data;
				REG_LIFT_B:      lift_b_q <= cfg_data;
				REG_LIFT_C:      lift_c_q <= cfg_data;
				REG_LIFT_D:      lift_d_q <= cfg_data;
				REG_HIGH_GAIN:   high_gain_q <= cfg_data;
				REG_LOW_GAIN:    low_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic     q_push, q_full, q_pop, q_nempty;
	fq_item_t q_wdata, q_rdata;

	dwt97_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .sample,
		.eff_len, .q_push, .q_data(q_wdata), .q_full
	);

	dwt97_fifo u_fifo (
		.clk, .arst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .rdata(q_rdata), .nempty(q_nempty)
	);

	dwt97_back u_back (
		.clk, .arst_n, .q_nempty, .q_data(q_rdata), .q_pop,
		.eff_len, .start_odd(start_odd_q),
		.lift_a(lift_a_q), .lift_b(lift_b_q), .lift_c(lift_c_q), .lift_d(lift_d_q),
		.high_gain(high_gain_q), .low_gain(low_gain_q),
		.out_valid, .out_stall, .coefficient, .band, .position, .last
	);
endmodule
